>>> hw/rtl/cref_pkg.sv
// Shared types and constants for the cell reference parser.
// No dependencies; compile before every other file of the block.
package cref_pkg;

  // Field widths
  localparam int CHAR_BITS     = 8;
  localparam int COL_BITS      = 16;
  localparam int ROW_BITS      = 32;
  localparam int LETTER_BITS   = 5;
  localparam int DIGIT_BITS    = 4;

  // The column accumulator holds the 1-based column and may reach 2^COL_BITS.
  localparam int COL_ACC_BITS  = COL_BITS + 1;
  // Room for accum * 26 + letter, and for accum * 10 + digit.
  localparam int COL_PROD_BITS = COL_ACC_BITS + LETTER_BITS;
  localparam int ROW_PROD_BITS = ROW_BITS + DIGIT_BITS;

  localparam int COL_RADIX     = 26;
  localparam int ROW_RADIX     = 10;

  localparam logic [COL_PROD_BITS-1:0] COL_LIMIT =
    COL_PROD_BITS'({1'b1, {COL_BITS{1'b0}}});
  localparam logic [ROW_PROD_BITS-1:0] ROW_LIMIT =
    ROW_PROD_BITS'({ROW_BITS{1'b1}});

  // Character codes
  localparam logic [CHAR_BITS-1:0] CH_DOLLAR  = 8'h24;
  localparam logic [CHAR_BITS-1:0] CH_COLON   = 8'h3A;
  localparam logic [CHAR_BITS-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_BITS-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CHAR_BITS-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_BITS-1:0] CH_LOWER_Z = 8'h7A;

  typedef enum logic [2:0] {
    PH_START,
    PH_COLFIRST,
    PH_COL,
    PH_ROWSTART,
    PH_ROWFIRST,
    PH_ROW,
    PH_STOP
  } phase_t;

  typedef struct packed {
    phase_t                  phase;
    logic [COL_ACC_BITS-1:0] col_accum;
    logic [ROW_BITS-1:0]     row_accum;
    logic                    col_abs;
    logic                    row_abs;
    logic                    saw_digit;
    logic                    sat;
  } parse_state_t;

  typedef struct packed {
    logic [COL_BITS-1:0] col_index;
    logic [ROW_BITS-1:0] row_index;
    logic                col_absolute;
    logic                row_absolute;
    logic                parse_ok;
    logic                overflow;
  } cell_result_t;

  localparam parse_state_t STATE_RESET = '{
    phase:     PH_START,
    col_accum: '0,
    row_accum: '0,
    col_abs:   1'b0,
    row_abs:   1'b0,
    saw_digit: 1'b0,
    sat:       1'b0
  };

endpackage

>>> hw/rtl/cref_char_if.sv
// Character request channel: valid/ready handshake with one character.
// Depends on cref_pkg.
interface cref_char_if;
  logic                          valid;
  logic                          ready;
  logic [cref_pkg::CHAR_BITS-1:0] char_code;
  logic                          is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

>>> hw/rtl/cref_cell_if.sv
// Result request channel: valid/ready handshake with one parsed reference.
// Depends on cref_pkg.
interface cref_cell_if;
  logic                          valid;
  logic                          ready;
  logic [cref_pkg::COL_BITS-1:0] col_index;
  logic [cref_pkg::ROW_BITS-1:0] row_index;
  logic                          col_absolute;
  logic                          row_absolute;
  logic                          parse_ok;
  logic                          overflow;

  modport source (output valid, output col_index, output row_index,
                  output col_absolute, output row_absolute,
                  output parse_ok, output overflow, input ready);
  modport sink   (input valid, input col_index, input row_index,
                  input col_absolute, input row_absolute,
                  input parse_ok, input overflow, output ready);
endinterface

>>> hw/rtl/cref_step.sv
// Next-state logic of the parser for one character, plus the result that
// the reference would give if this character is its last. Depends on cref_pkg.
module cref_step (
  input  cref_pkg::parse_state_t         cur,
  input  logic [cref_pkg::CHAR_BITS-1:0] char_code,
  output cref_pkg::parse_state_t         nxt,
  output cref_pkg::cell_result_t         result
);

  logic                                 is_letter;
  logic                                 is_digit;
  logic                                 is_dollar;
  logic                                 is_colon;
  logic [cref_pkg::LETTER_BITS-1:0]     letter_val;
  logic [cref_pkg::DIGIT_BITS-1:0]      digit_val;
  logic [cref_pkg::COL_PROD_BITS-1:0]   col_mac;
  logic [cref_pkg::ROW_PROD_BITS-1:0]   row_mac;
  logic                                 col_sat;
  logic                                 row_sat;
  logic [cref_pkg::COL_ACC_BITS-1:0]    col_added;
  logic [cref_pkg::ROW_BITS-1:0]        row_added;
  logic                                 do_letter;
  logic                                 do_digit;
  logic [cref_pkg::COL_ACC_BITS-1:0]    col_dec;
  logic [cref_pkg::ROW_BITS-1:0]        row_dec;
  logic                                 ok;

  // Character classes; both cases of a letter share the low five bits
  assign is_letter = (char_code >= cref_pkg::CH_UPPER_A && char_code <= cref_pkg::CH_UPPER_Z) ||
                     (char_code >= cref_pkg::CH_LOWER_A && char_code <= cref_pkg::CH_LOWER_Z);
  assign is_digit  = char_code >= cref_pkg::CH_ZERO && char_code <= cref_pkg::CH_NINE;
  assign is_dollar = char_code == cref_pkg::CH_DOLLAR;
  assign is_colon  = char_code == cref_pkg::CH_COLON;
  assign letter_val = char_code[cref_pkg::LETTER_BITS-1:0];
  assign digit_val  = char_code[cref_pkg::DIGIT_BITS-1:0];

  // Saturating multiply-add: accum > (limit - d) / r  iff  accum * r + d > limit
  assign col_mac = cref_pkg::COL_PROD_BITS'(cur.col_accum) *
                   cref_pkg::COL_PROD_BITS'(cref_pkg::COL_RADIX) +
                   cref_pkg::COL_PROD_BITS'(letter_val);
  assign col_sat   = col_mac > cref_pkg::COL_LIMIT;
  assign col_added = col_sat ? cref_pkg::COL_LIMIT[cref_pkg::COL_ACC_BITS-1:0]
                             : col_mac[cref_pkg::COL_ACC_BITS-1:0];

  assign row_mac = cref_pkg::ROW_PROD_BITS'(cur.row_accum) *
                   cref_pkg::ROW_PROD_BITS'(cref_pkg::ROW_RADIX) +
                   cref_pkg::ROW_PROD_BITS'(digit_val);
  assign row_sat   = row_mac > cref_pkg::ROW_LIMIT;
  assign row_added = row_sat ? cref_pkg::ROW_LIMIT[cref_pkg::ROW_BITS-1:0]
                             : row_mac[cref_pkg::ROW_BITS-1:0];

  // Phase transitions
  always_comb begin
    nxt       = cur;
    do_letter = 1'b0;
    do_digit  = 1'b0;
    unique case (cur.phase)
      cref_pkg::PH_START: begin
        if (is_dollar) begin
          nxt.col_abs = 1'b1;
          nxt.phase   = cref_pkg::PH_COLFIRST;
        end else if (is_letter) begin
          do_letter = 1'b1;
          nxt.phase = cref_pkg::PH_COL;
        end else begin
          nxt.phase = cref_pkg::PH_STOP;
        end
      end
      cref_pkg::PH_COLFIRST: begin
        if (is_letter) begin
          do_letter = 1'b1;
          nxt.phase = cref_pkg::PH_COL;
        end else begin
          nxt.phase = cref_pkg::PH_STOP;
        end
      end
      cref_pkg::PH_COL: begin
        if (is_letter) begin
          do_letter = 1'b1;
        end else if (is_colon) begin
          nxt.phase = cref_pkg::PH_ROWSTART;
        end else begin
          nxt.phase = cref_pkg::PH_STOP;
        end
      end
      cref_pkg::PH_ROWSTART: begin
        if (is_dollar) begin
          nxt.row_abs = 1'b1;
          nxt.phase   = cref_pkg::PH_ROWFIRST;
        end else if (is_digit) begin
          do_digit  = 1'b1;
          nxt.phase = cref_pkg::PH_ROW;
        end else begin
          nxt.phase = cref_pkg::PH_STOP;
        end
      end
      cref_pkg::PH_ROWFIRST, cref_pkg::PH_ROW: begin
        if (is_digit) begin
          do_digit  = 1'b1;
          nxt.phase = cref_pkg::PH_ROW;
        end else begin
          nxt.phase = cref_pkg::PH_STOP;
        end
      end
      default: begin
        nxt.phase = cref_pkg::PH_STOP;
      end
    endcase

    if (do_letter) begin
      nxt.col_accum = col_added;
      nxt.sat       = cur.sat | col_sat;
    end
    if (do_digit) begin
      nxt.row_accum = row_added;
      nxt.sat       = cur.sat | row_sat;
      nxt.saw_digit = 1'b1;
    end
  end

  // Result fields, taken from the state after this character
  assign col_dec = nxt.col_accum - cref_pkg::COL_ACC_BITS'(1);
  assign row_dec = nxt.row_accum - cref_pkg::ROW_BITS'(1);
  assign ok      = nxt.saw_digit && (nxt.row_accum != '0);

  assign result.col_index    = (nxt.col_accum != '0) ? col_dec[cref_pkg::COL_BITS-1:0] : '0;
  assign result.row_index    = ok ? row_dec : '0;
  assign result.col_absolute = nxt.col_abs;
  assign result.row_absolute = nxt.row_abs;
  assign result.parse_ok     = ok;
  assign result.overflow     = nxt.sat;

endmodule

>>> hw/rtl/cell_reference_parser_core.sv
// Parses an A1-style cell reference ([$]letters:[$]digits) sent one character
// per request, the final one marked with is_last, and returns one result per
// reference: 0-based column and row, the two absolute flags, an ok flag and
// an overflow flag. One character is taken every clock cycle while the input is
// not stalled; the last character of a reference passes through the input
// register into the result register, where the result sits until taken. The
// per-character update of the parse state is a saturating multiply-add on the
// row or column accumulator. While a result waits to be taken, characters of
// the next reference keep flowing; only its last character waits in the input
// register, and the input stalls behind it.
// Depends on cref_pkg, cref_char_if, cref_cell_if and cref_step.
module cell_reference_parser_core (
  input  logic                clk,
  input  logic                rst,
  cref_char_if.sink           chars,
  cref_cell_if.source         cells
);

  logic                          s1_valid;
  logic [cref_pkg::CHAR_BITS-1:0] s1_char;
  logic                          s1_last;
  logic                          s1_take;
  cref_pkg::parse_state_t        st;
  cref_pkg::parse_state_t        st_next;
  cref_pkg::cell_result_t        step_result;
  logic                          res_valid;
  cref_pkg::cell_result_t        res;

  // Input stage advances unless its last character would overwrite a waiting result
  assign s1_take     = s1_valid && !(s1_last && res_valid && !cells.ready);
  assign chars.ready = !s1_valid || s1_take;

  cref_step u_step (
    .cur       (st),
    .char_code (s1_char),
    .nxt       (st_next),
    .result    (step_result)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      st        <= cref_pkg::STATE_RESET;
      res_valid <= 1'b0;
    end else begin
      if (chars.ready) begin
        s1_valid <= chars.valid;
      end
      if (s1_take) begin
        st <= s1_last ? cref_pkg::STATE_RESET : st_next;
      end
      if (s1_take && s1_last) begin
        res_valid <= 1'b1;
      end else if (cells.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      s1_char <= chars.char_code;
      s1_last <= chars.is_last;
    end
    if (s1_take && s1_last) begin
      res <= step_result;
    end
  end

  assign cells.valid        = res_valid;
  assign cells.col_index    = res.col_index;
  assign cells.row_index    = res.row_index;
  assign cells.col_absolute = res.col_absolute;
  assign cells.row_absolute = res.row_absolute;
  assign cells.parse_ok     = res.parse_ok;
  assign cells.overflow     = res.overflow;

endmodule

>>> hw/rtl/cref_checker.sv
// Port-level assertions for cell_reference_parser_core, bound into that module.
// Depends on cref_pkg and cell_reference_parser_core.
module cref_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          chars_valid,
  input logic                          chars_ready,
  input logic                          cells_valid,
  input logic                          cells_ready,
  input logic [cref_pkg::COL_BITS-1:0] col_index,
  input logic [cref_pkg::ROW_BITS-1:0] row_index,
  input logic [3:0]                    flags
);

  logic chars_acc;
  assign chars_acc = chars_valid && chars_ready;

  // A waiting result holds its payload
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    cells_valid && !cells_ready |=>
      cells_valid && $stable(col_index) && $stable(row_index) && $stable(flags))
    else $error("result changed while stalled");

  // The character side only stalls behind a result that is not being taken
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !chars_ready |-> cells_valid && !cells_ready)
    else $error("character side stalled without a waiting result");

  // With no result waiting and chars_acc low both now and in its $past value, no result appears from nowhere
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !cells_valid && !chars_acc && !$past(chars_acc) |=> !cells_valid)
    else $error("result produced without a request");

endmodule

bind cell_reference_parser_core cref_checker u_cref_checker (
  .clk         (clk),
  .rst         (rst),
  .chars_valid (chars.valid),
  .chars_ready (chars.ready),
  .cells_valid (cells.valid),
  .cells_ready (cells.ready),
  .col_index   (cells.col_index),
  .row_index   (cells.row_index),
  .flags       ({cells.col_absolute, cells.row_absolute, cells.parse_ok, cells.overflow})
);

>>> verif/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for cell_reference_parser_core: directed references are
// checked against a table, random ones against an in-bench parser of their text.
// Depends on cref_pkg, cref_char_if, cref_cell_if and the parser RTL.
module tb;

  localparam int unsigned RANDOM_ITEMS = 530;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned MAX_REPORTS  = 10;

  logic clk;
  logic rst;

  cref_char_if chars ();
  cref_cell_if cells ();

  cell_reference_parser_core dut (
    .clk   (clk),
    .rst   (rst),
    .chars (chars),
    .cells (cells)
  );

  // Directed references; every result here can be read off directly
  typedef struct {
    string                  text;      // empty: raw_char is sent alone, marked last
    logic [7:0]             raw_char;
    cref_pkg::cell_result_t want;
  } directed_row_t;

  directed_row_t directed_rows [5] = '{
    // lowest and highest character codes, neither starts a reference
    '{"", 8'h00, '{16'd0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{"", 8'hFF, '{16'd0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
    // both absolute marks, lowercase column, trailing junk after the row
    '{"$a:$1$", 8'h00, '{16'd0, 32'd0, 1'b1, 1'b1, 1'b1, 1'b0}},
    // all-zero row fails but keeps the column
    '{"Z:00", 8'h00, '{16'd25, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
    // column and row both saturate, the parse still succeeds
    '{"zzzz:9999999999", 8'h00, '{16'hFFFF, 32'hFFFF_FFFE, 1'b0, 1'b0, 1'b1, 1'b1}}
  };

  // Parser state mirrored in the bench
  cref_pkg::phase_t                  cur_phase;
  logic [cref_pkg::COL_ACC_BITS-1:0] col_acc;
  logic [cref_pkg::ROW_BITS-1:0]     row_acc;
  bit                                col_abs_seen;
  bit                                row_abs_seen;
  bit                                digit_seen;
  bit                                saturated;

  cref_pkg::cell_result_t pending_cells [$];
  logic [7:0]             cell_text [$];
  cref_pkg::cell_result_t want_cell;
  cref_pkg::cell_result_t got_cell;
  int unsigned            error_count = 0;
  int unsigned            cycle_count = 0;

  int char_run_left = 0;
  bit char_no_wait  = 1'b0;
  int cell_run_left = 0;
  bit cell_no_wait  = 1'b0;

  function automatic void clear_parse();
    cur_phase    = cref_pkg::PH_START;
    col_acc      = '0;
    row_acc      = '0;
    col_abs_seen = 1'b0;
    row_abs_seen = 1'b0;
    digit_seen   = 1'b0;
    saturated    = 1'b0;
  endfunction

  // Bijective base-26 step, saturating at 2^COL_BITS
  function automatic void add_letter(input int unsigned letter);
    longint unsigned lim;
    lim = 64'd1 << cref_pkg::COL_BITS;
    if (col_acc > (lim - letter) / cref_pkg::COL_RADIX) begin
      col_acc   = lim[cref_pkg::COL_ACC_BITS-1:0];
      saturated = 1'b1;
    end else begin
      col_acc = cref_pkg::COL_ACC_BITS'(col_acc * cref_pkg::COL_RADIX + letter);
    end
  endfunction

  // Decimal step, saturating at all ones
  function automatic void add_digit(input logic [7:0] c);
    longint unsigned lim;
    longint unsigned d;
    lim = (64'd1 << cref_pkg::ROW_BITS) - 1;
    d   = 64'(c - cref_pkg::CH_ZERO);
    if (row_acc > (lim - d) / cref_pkg::ROW_RADIX) begin
      row_acc   = lim[cref_pkg::ROW_BITS-1:0];
      saturated = 1'b1;
    end else begin
      row_acc = cref_pkg::ROW_BITS'(row_acc * cref_pkg::ROW_RADIX + d);
    end
    digit_seen = 1'b1;
  endfunction

  // Advances the parse by one character; returns 1 with the cell on the last one
  function automatic bit parse_char(input logic [7:0] c, input bit last,
                                    output cref_pkg::cell_result_t res);
    int unsigned letter;
    bit          is_digit;
    bit          ok;
    letter = 0;
    if (c >= cref_pkg::CH_UPPER_A && c <= cref_pkg::CH_UPPER_Z)
      letter = c - cref_pkg::CH_UPPER_A + 1;
    else if (c >= cref_pkg::CH_LOWER_A && c <= cref_pkg::CH_LOWER_Z)
      letter = c - cref_pkg::CH_LOWER_A + 1;
    is_digit = (c >= cref_pkg::CH_ZERO && c <= cref_pkg::CH_NINE);
    res = '0;

    case (cur_phase)
      cref_pkg::PH_START: begin
        if (c == cref_pkg::CH_DOLLAR) begin
          col_abs_seen = 1'b1;
          cur_phase    = cref_pkg::PH_COLFIRST;
        end else if (letter != 0) begin
          add_letter(letter);
          cur_phase = cref_pkg::PH_COL;
        end else begin
          cur_phase = cref_pkg::PH_STOP;
        end
      end
      cref_pkg::PH_COLFIRST: begin
        if (letter != 0) begin
          add_letter(letter);
          cur_phase = cref_pkg::PH_COL;
        end else begin
          cur_phase = cref_pkg::PH_STOP;
        end
      end
      cref_pkg::PH_COL: begin
        if (letter != 0) add_letter(letter);
        else if (c == cref_pkg::CH_COLON) cur_phase = cref_pkg::PH_ROWSTART;
        else cur_phase = cref_pkg::PH_STOP;
      end
      cref_pkg::PH_ROWSTART: begin
        if (c == cref_pkg::CH_DOLLAR) begin
          row_abs_seen = 1'b1;
          cur_phase    = cref_pkg::PH_ROWFIRST;
        end else if (is_digit) begin
          add_digit(c);
          cur_phase = cref_pkg::PH_ROW;
        end else begin
          cur_phase = cref_pkg::PH_STOP;
        end
      end
      cref_pkg::PH_ROWFIRST, cref_pkg::PH_ROW: begin
        if (is_digit) begin
          add_digit(c);
          cur_phase = cref_pkg::PH_ROW;
        end else begin
          cur_phase = cref_pkg::PH_STOP;
        end
      end
      default: ;
    endcase

    if (!last) return 1'b0;

    ok = digit_seen && (row_acc != 0);
    res.col_index    = (col_acc != 0) ? cref_pkg::COL_BITS'(col_acc - 1) : '0;
    res.row_index    = ok ? row_acc - 1 : '0;
    res.col_absolute = col_abs_seen;
    res.row_absolute = row_abs_seen;
    res.parse_ok     = ok;
    res.overflow     = saturated;
    clear_parse();
    return 1'b1;
  endfunction

  // Wait before the next request; runs of back-to-back traffic and runs of
  // random gaps are picked at random
  function automatic int draw_wait(inout int run_left, inout bit no_wait);
    if (run_left == 0) begin
      run_left = $urandom_range(8, 40);
      no_wait  = ($urandom_range(0, 3) == 0);
    end
    run_left--;
    return no_wait ? 0 : int'($urandom_range(0, 13));
  endfunction

  // Random reference: mostly well formed, some corrupted or cut short,
  // some plain noise
  function automatic void build_random_text();
    int unsigned kind;
    int unsigned n;
    int unsigned pick;
    int unsigned cut;
    bit          zero_row;
    cell_text.delete();
    kind = $urandom_range(0, 99);
    if (kind >= 90) begin
      n = $urandom_range(1, 6);
      repeat (n) cell_text.push_back(8'($urandom_range(0, 255)));
      return;
    end

    if ($urandom_range(0, 1)) cell_text.push_back(cref_pkg::CH_DOLLAR);
    pick = $urandom_range(0, 19);
    if (pick < 12) n = 1;
    else if (pick < 16) n = 2;
    else if (pick < 18) n = 3;
    else n = $urandom_range(4, 5);
    repeat (n) begin
      cell_text.push_back(($urandom_range(0, 1) ? cref_pkg::CH_UPPER_A : cref_pkg::CH_LOWER_A) +
                          8'($urandom_range(0, 25)));
    end
    cell_text.push_back(cref_pkg::CH_COLON);
    if ($urandom_range(0, 1)) cell_text.push_back(cref_pkg::CH_DOLLAR);

    pick = $urandom_range(0, 19);
    if (pick < 14) n = $urandom_range(1, 3);
    else if (pick < 18) n = $urandom_range(4, 9);
    else n = $urandom_range(10, 11);
    zero_row = ($urandom_range(0, 19) == 0);
    repeat (n) begin
      cell_text.push_back(zero_row ? cref_pkg::CH_ZERO
                                   : cref_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    end
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 3)) cell_text.push_back(8'($urandom_range(0, 255)));
    end

    // broken: one character replaced, or the reference cut short
    if (kind >= 75) begin
      if ($urandom_range(0, 1)) begin
        cell_text[$urandom_range(0, cell_text.size() - 1)] = 8'($urandom_range(0, 255));
      end else begin
        cut = $urandom_range(1, cell_text.size() - 1);
        while (cell_text.size() > cut) void'(cell_text.pop_back());
      end
    end
  endfunction

  // Sends cell_text one request per character, the final one marked last
  task automatic send_text(input bit typed, input cref_pkg::cell_result_t want);
    int                     gap;
    int                     i;
    bit                     last;
    cref_pkg::cell_result_t parsed;
    for (i = 0; i < cell_text.size(); i++) begin
      last = (i == cell_text.size() - 1);
      gap  = draw_wait(char_run_left, char_no_wait);
      if (gap > 0) begin
        chars.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      chars.valid     <= 1'b1;
      chars.char_code <= cell_text[i];
      chars.is_last   <= last;
      do @(posedge clk); while (!chars.ready);
      if (parse_char(cell_text[i], last, parsed)) pending_cells.push_back(typed ? want : parsed);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Result side: random back-pressure
  initial begin
    int gap;
    cells.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      gap = draw_wait(cell_run_left, cell_no_wait);
      if (gap > 0) begin
        cells.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      cells.ready <= 1'b1;
      do @(posedge clk); while (!cells.valid);
    end
  end

  // Compare each accepted cell with the oldest expected one
  always @(posedge clk) begin
    if (!rst && cells.valid && cells.ready) begin
      got_cell = '{cells.col_index, cells.row_index, cells.col_absolute,
                   cells.row_absolute, cells.parse_ok, cells.overflow};
      if (pending_cells.size() == 0) begin
        if (error_count < MAX_REPORTS)
          $display("unexpected cell: col %0d row %0d cabs %b rabs %b ok %b ovf %b",
                   got_cell.col_index, got_cell.row_index, got_cell.col_absolute,
                   got_cell.row_absolute, got_cell.parse_ok, got_cell.overflow);
        error_count++;
      end else begin
        want_cell = pending_cells.pop_front();
        if (got_cell !== want_cell) begin
          if (error_count < MAX_REPORTS)
            $display({"cell mismatch: expected col %0d row %0d cabs %b rabs %b ok %b ovf %b,",
                      " got col %0d row %0d cabs %b rabs %b ok %b ovf %b"},
                     want_cell.col_index, want_cell.row_index, want_cell.col_absolute,
                     want_cell.row_absolute, want_cell.parse_ok, want_cell.overflow,
                     got_cell.col_index, got_cell.row_index, got_cell.col_absolute,
                     got_cell.row_absolute, got_cell.parse_ok, got_cell.overflow);
          error_count++;
        end
      end
    end
  end

  // Reset, directed references, random references, drain
  initial begin
    int unsigned sent;
    int          j;
    sent = 0;
    rst             <= 1'b1;
    chars.valid     <= 1'b0;
    chars.char_code <= '0;
    chars.is_last   <= 1'b0;
    clear_parse();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      cell_text.delete();
      if (directed_rows[i].text.len() == 0) begin
        cell_text.push_back(directed_rows[i].raw_char);
      end else begin
        for (j = 0; j < directed_rows[i].text.len(); j++)
          cell_text.push_back(directed_rows[i].text[j]);
      end
      send_text(1'b1, directed_rows[i].want);
    end

    while (sent < RANDOM_ITEMS) begin
      build_random_text();
      send_text(1'b0, '0);
      sent += cell_text.size();
    end
    chars.valid <= 1'b0;

    while (pending_cells.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_cells.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
